>>> design/tmac_pkg.sv
// ----------------------------------------------------------------------------
// tmac_pkg
// shared types and constants of the trimmed mean adc calibrator
// ----------------------------------------------------------------------------
package tmac_pkg;

  localparam int SAMPLE_W        = 12;
  localparam int SCALED_W        = 16;
  localparam int COUNT_W         = 4;
  localparam int GAIN_W          = 24;
  localparam int OFS_W           = 16;
  localparam int OFS_MAG_W       = 15;
  localparam int OFS_SIGN_BIT    = 15;
  localparam int FRAC_W          = 16;
  localparam int CFG_DATA_W      = 24;
  localparam int CFG_IDX_W       = 2;
  localparam int IN_TDATA_W      = 16;
  localparam int OUT_TDATA_W     = 32;

  localparam int MAX_SAMPLES_DEF = 10;
  localparam int TRIM_LIMIT      = 5;
  localparam int TRIM_DROP       = 4;

  localparam int MIN_GAIN_NUM    = 1000;
  localparam int Q_ONE           = 65536;
  localparam int MIN_GAIN        = (Q_ONE + MIN_GAIN_NUM - 1) / MIN_GAIN_NUM;

  localparam logic [COUNT_W-1:0] COUNT_RST  = COUNT_W'(10);
  localparam logic [GAIN_W-1:0]  GAIN_RST   = '0;
  localparam logic [OFS_W-1:0]   OFS_RST    = '0;
  localparam logic [GAIN_W-1:0]  DGAIN_RST  = GAIN_W'(Q_ONE);
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNT        = 2'd0,
    CFG_GAIN         = 2'd1,
    CFG_OFFSET       = 2'd2,
    CFG_DEFAULT_GAIN = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIM,
    ST_DIV,
    ST_CAL,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [GAIN_W-1:0]  gain;
    logic [OFS_W-1:0]   offset;
    logic [GAIN_W-1:0]  default_gain;
  } cfg_t;

endpackage

>>> design/tmac_div.sv
// ----------------------------------------------------------------------------
// tmac_div
// restoring divider, one quotient bit per cycle through a shared subtractor
// ----------------------------------------------------------------------------
module tmac_div #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [NUM_W-1:0] quot_q, quot_d;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, quot_q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
      rem_d  = '0;
      den_d  = den_i;
      quot_d = num_i;
    end else if (busy_q) begin
      rem_d  = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quot_d = {quot_q[NUM_W-2:0], fits};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> design/tmac_cal.sv
// ----------------------------------------------------------------------------
// tmac_cal
// two-stage calibration: slope multiply, then offset (only with a valid gain) and saturation
// ----------------------------------------------------------------------------
module tmac_cal (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [tmac_pkg::SAMPLE_W-1:0]  mean_i,
  input  tmac_pkg::cfg_t                 cfg_i,
  output logic                           done_o,
  output logic [tmac_pkg::SCALED_W-1:0]  scaled_o
);

  import tmac_pkg::*;

  localparam int PROD_W = SAMPLE_W + GAIN_W;
  localparam int HI_W   = PROD_W - FRAC_W;

  logic                    uncal;
  logic [GAIN_W-1:0]       slope;
  logic                    v1_q, done_q;
  logic [PROD_W-1:0]       prod_q;
  logic                    use_ofs_q, sub_q;
  logic [OFS_MAG_W-1:0]    mag_q;
  logic [HI_W-1:0]         hi;
  logic [HI_W:0]           sum_ext;
  logic [HI_W-1:0]         diff;
  logic [HI_W:0]           q_val;
  logic [SCALED_W-1:0]     res_d, res_q;

  assign uncal = (cfg_i.gain < GAIN_W'(MIN_GAIN));
  assign slope = uncal ? cfg_i.default_gain : cfg_i.gain;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q    <= PROD_W'(mean_i) * PROD_W'(slope);
      use_ofs_q <= !uncal;
      sub_q     <= cfg_i.offset[OFS_SIGN_BIT];
      mag_q     <= cfg_i.offset[OFS_MAG_W-1:0];
    end
  end

  assign hi      = prod_q[PROD_W-1:FRAC_W];
  assign sum_ext = {1'b0, hi} + (HI_W+1)'(mag_q);
  assign diff    = hi - HI_W'(mag_q);

  always_comb begin
    if (!use_ofs_q) begin
      q_val = {1'b0, hi};
    end else if (sub_q) begin
      q_val = (hi < HI_W'(mag_q)) ? '0 : {1'b0, diff};
    end else begin
      q_val = sum_ext;
    end
    res_d = (q_val > (HI_W+1)'({SCALED_W{1'b1}})) ? '1 : q_val[SCALED_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      done_q <= v1_q;
    end
  end

  assign done_o   = done_q;
  assign scaled_o = res_q;

endmodule

>>> design/trimmed_mean_adc_calibrator_unit.sv
// ----------------------------------------------------------------------------
// trimmed_mean_adc_calibrator_unit
// batch averager with min/max trimming and linear calibration
//
//   port group   dir  content (lsb first)
//   s_axis       in   tdata: sample[11:0]
//   m_axis       out  tdata: raw_mean[11:0], scaled_value[27:12]
//   cfg          in   write enable, index 0..3, data up to 24 bits
//
// a sample that does not close its batch is only accumulated; the closing
// sample is reduced in turn by trim, the serial divider and two calibration
// stages, and the result is then pushed to the output register
// s_axis_tready is low while a batch is reduced, and while a result is
// waiting and m_axis_tready is low; reset empties the batch and resets config state
// ----------------------------------------------------------------------------
module trimmed_mean_adc_calibrator_unit #(
  parameter int MAX_SAMPLES = tmac_pkg::MAX_SAMPLES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [tmac_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // sample
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tmac_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // raw_mean, scaled_value
  input  logic                              cfg_we_i,
  input  logic [tmac_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tmac_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import tmac_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = SAMPLE_W + $clog2(MAX_SAMPLES);

  cfg_t                cfg_q, cfg_d;
  state_e              state_q, state_d;
  logic [CW-1:0]       fill_q, fill_d;
  logic [CW-1:0]       n_eff, base_fill, fill_inc, den;
  logic [SW-1:0]       sum_q, sum_d, numer;
  logic [SAMPLE_W-1:0] max1_q, max1_d, max2_q, max2_d;
  logic [SAMPLE_W-1:0] min1_q, min1_d, min2_q, min2_d;
  logic [SAMPLE_W-1:0] smp;
  logic                accept, slot_free, trim;
  logic                load_zero, load_calc;
  logic                out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] out_mean_q;
  logic [SCALED_W-1:0] out_scaled_q;
  logic                div_start, div_done, cal_start, cal_done;
  logic [SW-1:0]       quot;
  logic [SCALED_W-1:0] scaled;

  // config port
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_COUNT:        cfg_d.count        = cfg_data_i[COUNT_W-1:0];
        CFG_GAIN:         cfg_d.gain         = cfg_data_i[GAIN_W-1:0];
        CFG_OFFSET:       cfg_d.offset       = cfg_data_i[OFS_W-1:0];
        CFG_DEFAULT_GAIN: cfg_d.default_gain = cfg_data_i[GAIN_W-1:0];
        default:          cfg_d              = cfg_q;
      endcase
    end
  end

  assign n_eff     = (int'(cfg_q.count) > MAX_SAMPLES) ? CW'(MAX_SAMPLES)
                                                      : CW'(cfg_q.count);
  assign trim      = (int'(n_eff) > TRIM_LIMIT);
  assign smp       = s_axis_tdata[SAMPLE_W-1:0];
  assign slot_free = !out_valid_q || m_axis_tready;
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign base_fill = (fill_q >= n_eff) ? '0 : fill_q;
  assign fill_inc  = base_fill + CW'(1);
  assign load_zero = accept && (n_eff == '0);
  assign load_calc = (state_q == ST_PUSH) && slot_free;

  // running sum and the two largest and two smallest samples of the batch
  always_comb begin
    fill_d = fill_q;
    sum_d  = sum_q;
    max1_d = max1_q;
    max2_d = max2_q;
    min1_d = min1_q;
    min2_d = min2_q;
    if (load_zero) begin
      fill_d = '0;
    end else if (accept) begin
      fill_d = (fill_inc == n_eff) ? '0 : fill_inc;
      if (base_fill == '0) begin
        sum_d  = SW'(smp);
        max1_d = smp;
        max2_d = '0;
        min1_d = smp;
        min2_d = SAMPLE_MAX;
      end else begin
        sum_d = sum_q + SW'(smp);
        if (smp >= max1_q) begin
          max2_d = max1_q;
          max1_d = smp;
        end else if (smp > max2_q) begin
          max2_d = smp;
        end
        if (smp <= min1_q) begin
          min2_d = min1_q;
          min1_d = smp;
        end else if (smp < min2_q) begin
          min2_d = smp;
        end
      end
    end
  end

  assign numer = trim ? (sum_q - SW'(max1_q) - SW'(max2_q) - SW'(min1_q) - SW'(min2_q))
                      : sum_q;
  assign den   = trim ? (n_eff - CW'(TRIM_DROP)) : n_eff;

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept && n_eff != '0 && fill_inc == n_eff) state_d = ST_TRIM;
      ST_TRIM: state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_CAL;
      ST_CAL:  if (cal_done) state_d = ST_PUSH;
      ST_PUSH: if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    cal_start     = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = slot_free;
      ST_TRIM: div_start     = 1'b1;
      ST_DIV:  cal_start     = div_done;
      ST_CAL:  s_axis_tready = 1'b0;
      ST_PUSH: s_axis_tready = 1'b0;
      default: s_axis_tready = 1'b0;
    endcase
  end

  tmac_div #(
    .NUM_W (SW),
    .DEN_W (CW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (numer),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  tmac_cal u_cal (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cal_start),
    .mean_i   (quot[SAMPLE_W-1:0]),
    .cfg_i    (cfg_q),
    .done_o   (cal_done),
    .scaled_o (scaled)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_zero || load_calc) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_zero) begin
      out_mean_q   <= '0;
      out_scaled_q <= '0;
    end else if (load_calc) begin
      out_mean_q   <= quot[SAMPLE_W-1:0];
      out_scaled_q <= scaled;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    max1_q <= max1_d;
    max2_q <= max2_d;
    min1_q <= min1_d;
    min2_q <= min2_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.count        <= COUNT_RST;
      cfg_q.gain         <= GAIN_RST;
      cfg_q.offset       <= OFS_RST;
      cfg_q.default_gain <= DGAIN_RST;
      state_q            <= ST_IDLE;
      fill_q             <= '0;
      out_valid_q        <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - SAMPLE_W - SCALED_W)'(0), out_scaled_q, out_mean_q};

endmodule
